// ----- design/pmul_pkg.sv -----
// shared constants and types of the polynomial multiplication unit
package pmul_pkg;

	// coefficient storage per operand
	localparam int MAX_COEFFS = 32;
	localparam int IDX_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
	localparam int CNT_W = $clog2(MAX_COEFFS + 1);
	// product degree count, up to 2 * MAX_COEFFS - 1
	localparam int TOT_W = CNT_W + 1;

	localparam int COEF_W = 32;
	localparam int PROD_W = 2 * COEF_W;
	// exact sum of up to MAX_COEFFS products plus sign
	localparam int ACC_W = PROD_W + CNT_W;
	localparam int FRAC_W = 16;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_SETUP,
		ST_ISSUE,
		ST_DRAIN,
		ST_OUT
	} pmul_state_t;

	// term control that travels with the operand pair
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} pmul_term_t;

endpackage

// ----- design/polynomial_multiplication_unit.sv -----
// top level of the polynomial multiplication unit
// Loads two polynomials of signed Q16.16 coefficients, lowest degree first, first operand
// then second, each closed by last_coefficient or declared empty by empty_operand; when the
// second operand completes, the product coefficients come out lowest degree first. Each
// operand holds up to MAX_COEFFS (32) coefficients, extra ones are dropped and flag
// capacity_overflow on every result of that product. An empty or unloaded operand gives one
// result with empty_result set; an operand that is a single zero gives one 0. Otherwise each
// product coefficient is the exact sum of its 64-bit terms, shifted right by 16 (toward
// minus infinity) and clipped to 32 bits with saturated set. The product runs on one shared
// 32x32 multiplier and accumulator with one term per cycle: each product coefficient passes
// through a setup step, its term issues, memory read, multiply and accumulate, and an output
// step, and result_stall holds the output step. operand_stall stays high until the last
// result is taken.
module polynomial_multiplication_unit
	import pmul_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// operand channel
	input  logic                     operand_valid,
	output logic                     operand_stall,
	input  logic                     operand_select,
	input  logic signed [COEF_W-1:0] coefficient,
	input  logic                     last_coefficient,
	input  logic                     empty_operand,
	// result channel
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [COEF_W-1:0] product_coefficient,
	output logic                     last_result,
	output logic                     empty_result,
	output logic                     saturated,
	output logic                     capacity_overflow
);

	pmul_state_t state_q, state_d;

	// coefficient memories
	logic [COEF_W-1:0] first_mem [MAX_COEFFS];
	logic [COEF_W-1:0] second_mem [MAX_COEFFS];

	// operand bookkeeping
	logic [CNT_W-1:0] first_cnt_q, second_cnt_q;
	logic             first_done_q;
	logic             first_empty_q, second_empty_q;
	logic             first_zero_q, second_zero_q;
	logic             overflow_q;

	// load side
	logic             accept;
	logic [CNT_W-1:0] cnt_eff;
	logic             room;
	logic             wr_en;
	logic             start_product;

	// sequencer
	logic [TOT_W-1:0] k_q, total_q;
	logic [IDX_W-1:0] i_q, i_end_q;
	logic             first_term_q;
	logic [TOT_W-1:0] n1_ext, n2_ext, n1_m1;
	logic [TOT_W-1:0] i_start, i_end, j_full;
	logic             last_term;

	// memory read stage
	logic signed [COEF_W-1:0] a_s1, b_s1;
	pmul_term_t               term_s1;
	pmul_term_t               term_issue;

	// mac outputs
	logic                     mac_done;
	logic signed [COEF_W-1:0] mac_coef;
	logic                     mac_sat;

	logic out_take;
	logic e1, e2;

	assign accept        = operand_valid & ~operand_stall;
	assign operand_stall = (state_q != ST_LOAD);
	assign result_valid  = (state_q == ST_OUT);
	assign out_take      = result_valid & ~result_stall;

	// a reloaded first operand restarts from zero; the second never stays done
	assign cnt_eff = operand_select ? second_cnt_q : (first_done_q ? '0 : first_cnt_q);
	assign room    = (cnt_eff < CNT_W'(MAX_COEFFS));
	assign wr_en   = accept & ~empty_operand & room;
	assign start_product = accept & operand_select & (empty_operand | last_coefficient);

	assign e1 = first_empty_q | (first_cnt_q == '0);
	assign e2 = second_empty_q | (second_cnt_q == '0);

	// term range for degree k: i from max(0, k-n2+1) to min(k, n1-1)
	assign n1_ext  = TOT_W'(first_cnt_q);
	assign n2_ext  = TOT_W'(second_cnt_q);
	assign n1_m1   = n1_ext - TOT_W'(1);
	assign i_start = (k_q >= n2_ext) ? (k_q - n2_ext + TOT_W'(1)) : '0;
	assign i_end   = (k_q < n1_m1) ? k_q : n1_m1;
	assign j_full  = k_q - TOT_W'(i_q);
	assign last_term = (i_q == i_end_q);

	always_comb begin
		term_issue.valid = (state_q == ST_ISSUE);
		term_issue.first = first_term_q;
		term_issue.last  = last_term;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (start_product) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (e1 | e2 | (first_cnt_q == CNT_W'(1) & first_zero_q)
					| (second_cnt_q == CNT_W'(1) & second_zero_q)) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: state_d = ST_ISSUE;
			ST_ISSUE: begin
				if (last_term) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (mac_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_take) begin
					state_d = last_result ? ST_LOAD : ST_SETUP;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// operand bookkeeping, cleared once the whole product is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q    <= '0;
			second_cnt_q   <= '0;
			first_done_q   <= 1'b0;
			first_empty_q  <= 1'b0;
			second_empty_q <= 1'b0;
			overflow_q     <= 1'b0;
		end else if (out_take && last_result) begin
			first_cnt_q    <= '0;
			second_cnt_q   <= '0;
			first_done_q   <= 1'b0;
			first_empty_q  <= 1'b0;
			second_empty_q <= 1'b0;
			overflow_q     <= 1'b0;
		end else if (accept) begin
			if (!empty_operand && !room) begin
				overflow_q <= 1'b1;
			end
			if (!operand_select) begin
				if (empty_operand) begin
					first_cnt_q   <= '0;
					first_empty_q <= 1'b1;
					first_done_q  <= 1'b1;
				end else begin
					first_cnt_q   <= room ? cnt_eff + CNT_W'(1) : cnt_eff;
					first_empty_q <= 1'b0;
					first_done_q  <= last_coefficient;
				end
			end else begin
				if (empty_operand) begin
					second_cnt_q   <= '0;
					second_empty_q <= 1'b1;
				end else begin
					second_cnt_q   <= room ? cnt_eff + CNT_W'(1) : cnt_eff;
					second_empty_q <= 1'b0;
				end
			end
		end
	end

	// zero test on the lowest coefficient, kept beside the memory
	always_ff @(posedge clk) begin
		if (wr_en && cnt_eff == '0) begin
			if (!operand_select) begin
				first_zero_q <= (coefficient == '0);
			end else begin
				second_zero_q <= (coefficient == '0);
			end
		end
	end

	// coefficient memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (wr_en && !operand_select) begin
			first_mem[cnt_eff[IDX_W-1:0]] <= coefficient;
		end
		if (wr_en && operand_select) begin
			second_mem[cnt_eff[IDX_W-1:0]] <= coefficient;
		end
		a_s1 <= first_mem[i_q];
		b_s1 <= second_mem[j_full[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_s1 <= '0;
		end else begin
			term_s1 <= term_issue;
		end
	end

	// degree and term counters
	always_ff @(posedge clk) begin
		case (state_q)
			ST_START: begin
				k_q     <= '0;
				total_q <= n1_ext + n2_ext - TOT_W'(1);
			end
			ST_SETUP: begin
				i_q          <= i_start[IDX_W-1:0];
				i_end_q      <= i_end[IDX_W-1:0];
				first_term_q <= 1'b1;
			end
			ST_ISSUE: begin
				i_q          <= i_q + IDX_W'(1);
				first_term_q <= 1'b0;
			end
			ST_OUT: begin
				if (out_take) begin
					k_q <= k_q + TOT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_START) begin
			product_coefficient <= '0;
			last_result         <= 1'b1;
			empty_result        <= e1 | e2;
			saturated           <= 1'b0;
			capacity_overflow   <= overflow_q;
		end else if (state_q == ST_DRAIN && mac_done) begin
			product_coefficient <= mac_coef;
			last_result         <= (k_q + TOT_W'(1) == total_q);
			empty_result        <= 1'b0;
			saturated           <= mac_sat;
			capacity_overflow   <= overflow_q;
		end
	end

	pmul_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.term   (term_s1),
		.a      (a_s1),
		.b      (b_s1),
		.done   (mac_done),
		.coef   (mac_coef),
		.sat    (mac_sat)
	);

endmodule

// ----- design/pmul_mac.sv -----
// shared multiply-accumulate unit with output shift and saturation
module pmul_mac
	import pmul_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  pmul_term_t               term,
	input  logic signed [COEF_W-1:0] a,
	input  logic signed [COEF_W-1:0] b,
	output logic                     done,
	output logic signed [COEF_W-1:0] coef,
	output logic                     sat
);

	logic signed [PROD_W-1:0] prod_s2;
	pmul_term_t               term_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;
	logic [ACC_W-FRAC_W-1:0]  shifted;
	logic [ACC_W-FRAC_W-COEF_W:0] upper;
	logic                     fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_s2 <= '0;
			done_q  <= 1'b0;
		end else begin
			term_s2 <= term;
			done_q  <= term_s2.valid & term_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
		if (term_s2.valid) begin
			acc_q <= (term_s2.first ? '0 : acc_q)
				+ {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// arithmetic shift right, then clip to the coefficient range
	assign shifted = acc_q[ACC_W-1:FRAC_W];
	assign upper   = shifted[ACC_W-FRAC_W-1:COEF_W-1];
	assign fits    = (&upper) | ~(|upper);

	always_comb begin
		if (fits) begin
			coef = shifted[COEF_W-1:0];
			sat  = 1'b0;
		end else begin
			coef = acc_q[ACC_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
			sat  = 1'b1;
		end
	end

	assign done = done_q;

endmodule
